// ===== hw/rtl/lfnst_pkg.sv =====
package lfnst_pkg;

  localparam int NUM_INPUTS   = 16;
  localparam int MAX_OUTPUTS  = 48;
  localparam int SMALL_OUTPUTS = 16;
  localparam int WEIGHT_DEPTH = 768;

  localparam int WIDX_W = 10;
  localparam int WVAL_W = 8;
  localparam int CIDX_W = 4;
  localparam int CVAL_W = 16;
  localparam int PROD_W = CVAL_W + WVAL_W;
  localparam int ACC_W  = PROD_W + 4;
  localparam int OUT_W  = 16;

  localparam logic [63:0] SCAN_ORDER = 64'hfbe7ad369c258140;

  localparam logic [1:0] KIND_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_LOAD_COEF   = 2'd1;
  localparam logic [1:0] KIND_RUN         = 2'd2;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  function automatic logic [CIDX_W-1:0] scan_pos(input logic [3:0] term);
    return SCAN_ORDER[{term, 2'b00} +: CIDX_W];
  endfunction

endpackage

// ===== hw/rtl/lfnst_mac.sv =====
module lfnst_mac
  import lfnst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [CVAL_W-1:0] coef,
  input  logic signed [WVAL_W-1:0] weight,
  input  logic                     take,
  output logic                     res_valid,
  output logic signed [OUT_W-1:0]  res_value
);

  mac_ctl_t                 prod_ctl;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shifted;

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl  <= '0;
      res_valid <= 1'b0;
    end else begin
      prod_ctl <= ctl;
      // hold the finished sum until the sequencer takes it
      if (prod_ctl.valid && prod_ctl.last) begin
        res_valid <= 1'b1;
      end else if (take) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= coef * weight;
    if (prod_ctl.valid) begin
      acc <= prod_ctl.first ? prod_ext : acc + prod_ext;
    end
  end

  assign rnd     = acc + ACC_W'(64);
  assign shifted = rnd >>> 7;

  always_comb begin
    if (shifted > ACC_W'(32767)) begin
      res_value = 16'sh7fff;
    end else if (shifted < -ACC_W'(32768)) begin
      res_value = 16'sh8000;
    end else begin
      res_value = shifted[OUT_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/lfnst_inverse_transform_core.sv =====
// Inverse LFNST core. Requests arrive on the s_axis side: tuser selects a
// weight load, a coefficient load or a run. Loads are accepted in the idle
// state and leave it idle. A run produces 16 results (small kernel) or 48
// results (large kernel) on m_axis, tlast on the final one. Each result is a
// dot product of 8 or 16 terms computed one term per cycle through the
// single read port of the weight memory. No new request is taken until the
// last result of a run sits in the output register. Weights and coefficients
// must be loaded before a run reads them.
module lfnst_inverse_transform_core
  import lfnst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // weight_index[9:0], weight_value[17:10], coef_index[21:18],
  // coef_value[37:22], transposed[38], large_kernel[39], log2_width[42:40],
  // log2_height[45:43], zero[47:46]
  input  logic [47:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_value[15:0], out_row[18:16], out_col[21:19], out_offset[30:22],
  // zero[31]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [WIDX_W-1:0]        in_widx;
  logic signed [WVAL_W-1:0] in_wval;
  logic [CIDX_W-1:0]        in_cidx;
  logic signed [CVAL_W-1:0] in_cval;
  logic                     in_trans;
  logic                     in_large;
  logic [2:0]               in_lw;
  logic [2:0]               in_lh;
  logic                     in_acc;

  logic [1:0]        state;
  logic [5:0]        out_idx;
  logic [3:0]        term;
  logic [WIDX_W-1:0] waddr;
  logic              run_large;
  logic              run_trans;
  logic              run_terms16;
  logic [2:0]        run_lw;

  logic signed [WVAL_W-1:0] weight_mem [WEIGHT_DEPTH];
  logic signed [CVAL_W-1:0] coef_mem [NUM_INPUTS];
  logic signed [WVAL_W-1:0] w_rd;
  logic signed [CVAL_W-1:0] c_rd;

  mac_ctl_t          ctl0;
  mac_ctl_t          ctl1;
  logic              res_valid;
  logic signed [OUT_W-1:0] res_value;

  logic [3:0]        last_term;
  logic              last_out;
  logic [WIDX_W-1:0] stride;
  logic              out_free;
  logic              out_load;
  logic [2:0]        pos_r;
  logic [2:0]        pos_c;
  logic [2:0]        row;
  logic [2:0]        col;
  logic [10:0]       row_shift;
  logic [10:0]       offset_full;

  logic signed [OUT_W-1:0] o_value;
  logic [2:0]              o_row;
  logic [2:0]              o_col;
  logic [8:0]              o_offset;

  assign in_widx  = s_axis_tdata[9:0];
  assign in_wval  = s_axis_tdata[17:10];
  assign in_cidx  = s_axis_tdata[21:18];
  assign in_cval  = s_axis_tdata[37:22];
  assign in_trans = s_axis_tdata[38];
  assign in_large = s_axis_tdata[39];
  assign in_lw    = s_axis_tdata[42:40];
  assign in_lh    = s_axis_tdata[45:43];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign last_term = run_terms16 ? 4'd15 : 4'd7;
  assign last_out  = out_idx == (run_large ? 6'(MAX_OUTPUTS - 1) : 6'(SMALL_OUTPUTS - 1));
  assign stride    = run_large ? WIDX_W'(MAX_OUTPUTS) : WIDX_W'(NUM_INPUTS);
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign out_load  = (state == ST_EMIT) && res_valid && out_free;

  assign ctl0.valid = (state == ST_ISSUE);
  assign ctl0.first = (term == 4'd0);
  assign ctl0.last  = (term == last_term);

  // weight memory: one write port for loads, one read port for the run
  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tuser == KIND_LOAD_WEIGHT && in_widx < WIDX_W'(WEIGHT_DEPTH)) begin
      weight_mem[in_widx] <= in_wval;
    end
    w_rd <= weight_mem[waddr];
  end

  // coefficients are read in diagonal scan order
  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tuser == KIND_LOAD_COEF) begin
      coef_mem[in_cidx] <= in_cval;
    end
    c_rd <= coef_mem[scan_pos(term)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= ctl0;
    end
  end

  lfnst_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl1),
    .coef      (c_rd),
    .weight    (w_rd),
    .take      (out_load),
    .res_valid (res_valid),
    .res_value (res_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc && s_axis_tuser == KIND_RUN) begin
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (term == last_term) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            state <= last_out ? ST_IDLE : ST_ISSUE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        run_large   <= in_large;
        run_trans   <= in_trans;
        run_terms16 <= in_large || (in_lw != in_lh);
        run_lw      <= in_lw;
        out_idx     <= 6'd0;
        term        <= 4'd0;
        waddr       <= '0;
      end
      ST_ISSUE: begin
        term  <= term + 4'd1;
        waddr <= waddr + stride;
      end
      ST_EMIT: begin
        // advance to the next output
        if (out_load) begin
          out_idx <= out_idx + 6'd1;
          term    <= 4'd0;
          waddr   <= WIDX_W'(out_idx) + WIDX_W'(1);
        end
      end
      default: begin
        term <= 4'd0;
      end
    endcase
  end

  always_comb begin
    if (!run_large) begin
      pos_r = {1'b0, out_idx[3:2]};
      pos_c = {1'b0, out_idx[1:0]};
    end else if (!out_idx[5]) begin
      pos_r = {1'b0, out_idx[4:3]};
      pos_c = out_idx[2:0];
    end else begin
      pos_r = {1'b1, out_idx[3:2]};
      pos_c = {1'b0, out_idx[1:0]};
    end
  end

  assign row         = run_trans ? pos_c : pos_r;
  assign col         = run_trans ? pos_r : pos_c;
  assign row_shift   = {8'b0, row} << run_lw;
  assign offset_full = row_shift + {8'b0, col};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_value      <= res_value;
      o_row        <= row;
      o_col        <= col;
      o_offset     <= offset_full[8:0];
      m_axis_tlast <= last_out;
    end
  end

  assign m_axis_tdata = {1'b0, o_offset, o_col, o_row, o_value};

  a_sum_not_early: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |-> !res_valid)
    else $error("accumulated sum pending while terms are still issued");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_out) |=> (state == ST_IDLE))
    else $error("run did not end after its final result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_EMIT))
    else $error("result presented outside the emit step");

endmodule
